// ----- rtl/core/sha1s_pkg.sv -----
// Package for the SHA-1 stream hasher.
// Holds the initial hash values, round constants, request codes and the round function.
// No dependencies.
package sha1s_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned NumWord = 5;
    localparam int unsigned BlockW  = 512;
    localparam int unsigned MsgW    = 61;
    localparam int unsigned RoundW  = 7;
    localparam int unsigned IdxW    = 3;

    typedef logic [NumWord-1:0][WordW-1:0] t_hash;

    localparam t_hash HASH_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [WordW-1:0] K_0 = 32'h5A827999;
    localparam logic [WordW-1:0] K_1 = 32'h6ED9EBA1;
    localparam logic [WordW-1:0] K_2 = 32'h8F1BBCDC;
    localparam logic [WordW-1:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic REQ_DATA     = 1'b0;
    localparam logic REQ_FINALIZE = 1'b1;

    localparam logic [RoundW-1:0] LAST_ROUND = 7'd79;
    localparam logic [IdxW-1:0]   LAST_IDX   = 3'd4;

    // Round function plus round constant.
    function automatic logic [WordW-1:0] round_fk(
        input logic [RoundW-1:0] round,
        input logic [WordW-1:0]  b,
        input logic [WordW-1:0]  c,
        input logic [WordW-1:0]  d
    );
        logic [WordW-1:0] res;
        case (round) inside
            [7'd0:7'd19]:  res = ((b & c) | (~b & d)) + K_0;
            [7'd20:7'd39]: res = (b ^ c ^ d) + K_1;
            [7'd40:7'd59]: res = ((b & c) | (b & d) | (c & d)) + K_2;
            default:       res = (b ^ c ^ d) + K_3;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/core/sha1_stream_hasher_top.sv -----
// A data beat adds one byte; one that fills a 64-byte block starts a compression.
// A finalize beat adds the pad byte, zero bytes and the length, then a compression;
// with fewer than 9 bytes of room left it first pads out and compresses the current
// block, then pads a second block and compresses it. The 5 digest beats follow.
// One SHA-1 round per cycle; ready is high only when idle.
// Reset (i_rst_n, synchronous, active low) loads the initial hash values; uses sha1s_pkg.
module sha1_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_axis_tuser,   // [2:0] word_index
    output logic        o_m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    localparam int unsigned WordW = sha1s_pkg::WordW;
    localparam int unsigned BlkW  = sha1s_pkg::BlockW;

    t_state                            r_state;
    sha1s_pkg::t_hash                  r_h;
    sha1s_pkg::t_hash                  r_v;
    logic [BlkW-1:0]                   r_blk;
    logic [5:0]                        r_fill;
    logic [sha1s_pkg::MsgW-1:0]        r_msg;
    logic [sha1s_pkg::RoundW-1:0]      r_round;
    logic [sha1s_pkg::IdxW-1:0]        r_idx;
    logic                              r_pad_first;
    logic                              r_final;
    logic                              r_ret_pad;

    logic [63:0]      n_len_sh;
    logic [7:0]       n_pad_byte;
    logic [WordW-1:0] n_wsum;
    logic [WordW-1:0] n_wnew;
    logic [WordW-1:0] n_wcur;
    logic [WordW-1:0] n_t;

    always_comb begin
        n_len_sh   = {r_msg, 3'b000} << {r_fill[2:0], 3'b000};
        n_pad_byte = r_pad_first ? sha1s_pkg::PAD_BYTE : 8'h00;
        n_wcur     = r_blk[BlkW-1 -: WordW];
        n_wsum     = r_blk[BlkW-1-13*WordW -: WordW] ^ r_blk[BlkW-1-8*WordW -: WordW]
                   ^ r_blk[BlkW-1-2*WordW -: WordW] ^ n_wcur;
        n_wnew     = {n_wsum[WordW-2:0], n_wsum[WordW-1]};
        n_t        = {r_v[0][WordW-6:0], r_v[0][WordW-1 -: 5]}
                   + sha1s_pkg::round_fk(r_round, r_v[1], r_v[2], r_v[3])
                   + r_v[4] + n_wcur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_h         <= sha1s_pkg::HASH_IV;
            r_fill      <= '0;
            r_msg       <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            r_pad_first <= 1'b0;
            r_final     <= 1'b0;
            r_ret_pad   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        if (i_s_axis_tuser == sha1s_pkg::REQ_DATA) begin
                            r_blk  <= {r_blk[BlkW-9:0], i_s_axis_tdata};
                            r_fill <= r_fill + 6'd1;
                            r_msg  <= r_msg + 61'd1;
                            if (r_fill == 6'd63) begin
                                r_v       <= r_h;
                                r_round   <= '0;
                                r_final   <= 1'b0;
                                r_ret_pad <= 1'b0;
                                r_state   <= S_ROUND;
                            end
                        end else begin
                            r_pad_first <= 1'b1;
                            r_state     <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_blk       <= {r_blk[BlkW-9:0], n_pad_byte};
                    r_fill      <= r_fill + 6'd1;
                    r_pad_first <= 1'b0;
                    if (r_fill == 6'd63) begin
                        r_v       <= r_h;
                        r_round   <= '0;
                        r_final   <= 1'b0;
                        r_ret_pad <= 1'b1;
                        r_state   <= S_ROUND;
                    end else if (r_fill == 6'd55) begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_blk  <= {r_blk[BlkW-9:0], n_len_sh[63:56]};
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        r_v       <= r_h;
                        r_round   <= '0;
                        r_final   <= 1'b1;
                        r_ret_pad <= 1'b0;
                        r_state   <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_v     <= {r_v[3], r_v[2], {r_v[1][1:0], r_v[1][WordW-1:2]}, r_v[0], n_t};
                    r_blk   <= {r_blk[BlkW-WordW-1:0], n_wnew};
                    r_round <= r_round + 7'd1;
                    if (r_round == sha1s_pkg::LAST_ROUND) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < sha1s_pkg::NumWord; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    if (r_final) begin
                        r_idx   <= '0;
                        r_state <= S_OUT;
                    end else if (r_ret_pad) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (i_m_axis_tready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == sha1s_pkg::LAST_IDX) begin
                            r_h     <= sha1s_pkg::HASH_IV;
                            r_fill  <= '0;
                            r_msg   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_h <= {r_h[0], r_h[4], r_h[3], r_h[2], r_h[1]};
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = r_h[0];
    assign o_m_axis_tuser  = r_idx;
    assign o_m_axis_tlast  = (r_idx == sha1s_pkg::LAST_IDX);

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("input ready while a digest beat is pending");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast |=> o_s_axis_tready)
        else $error("block not idle after the last digest beat");

    a_first_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> (o_m_axis_tuser == 3'd0))
        else $error("digest does not start at word zero");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser <= sha1s_pkg::LAST_IDX))
        else $error("digest word index out of range");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for sha1_stream_hasher_top: byte beats and finalize beats go in,
// and every digest beat that comes out is compared with a SHA-1 predictor or a known digest.
// Depends on sha1s_pkg and sha1_stream_hasher_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] IV_0 = 32'h67452301;
    localparam logic [31:0] IV_1 = 32'hEFCDAB89;
    localparam logic [31:0] IV_2 = 32'h98BADCFE;
    localparam logic [31:0] IV_3 = 32'h10325476;
    localparam logic [31:0] IV_4 = 32'hC3D2E1F0;
    localparam logic [159:0] DIGEST_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] DIGEST_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_beat;

    typedef struct {
        logic        req;
        logic [7:0]  data_b;
        bit          typed;
        logic [159:0] digest;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    logic [31:0] chain_h [0:4];
    logic [7:0]  blk_buf [0:63];
    int unsigned fill_cnt;
    logic [60:0] msg_len;

    t_digest_beat digest_expect_q[$];
    t_stim_row    dir_rows[$];
    int           error_count;
    int           items_sent;
    int           rx_beats;
    int           burst_left;
    int           boundary_lens [0:8] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

    sha1_stream_hasher_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("sha1_stream_hasher_top regression: fail");
        $finish;
    end

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic sha1_restart();
        chain_h[0] = IV_0;
        chain_h[1] = IV_1;
        chain_h[2] = IV_2;
        chain_h[3] = IV_3;
        chain_h[4] = IV_4;
        fill_cnt = 0;
        msg_len = '0;
    endtask

    task automatic sha1_compress();
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, t;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        for (i = 16; i < 80; i++)
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (i = 0; i < 80; i++) begin
            if (i < 20)
                f = ((b & c) | (~b & d)) + 32'h5A827999;
            else if (i < 40)
                f = (b ^ c ^ d) + 32'h6ED9EBA1;
            else if (i < 60)
                f = ((b & c) | (b & d) | (c & d)) + 32'h8F1BBCDC;
            else
                f = (b ^ c ^ d) + 32'hCA62C1D6;
            t = rotl(a, 5) + f + e + w[i];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // Advances the predicted hash state by one accepted beat and, on a finalize,
    // queues the five digest words unless the caller supplies them itself.
    task automatic absorb_beat(input logic req, input logic [7:0] data_b, input bit keep);
        logic [63:0] bit_len;
        t_digest_beat db;
        int i;
        if (req == sha1s_pkg::REQ_DATA) begin
            blk_buf[fill_cnt] = data_b;
            fill_cnt++;
            msg_len = msg_len + 61'd1;
            if (fill_cnt == 64) begin
                sha1_compress();
                fill_cnt = 0;
            end
        end else begin
            blk_buf[fill_cnt] = 8'h80;
            fill_cnt++;
            if (fill_cnt > 56) begin
                for (i = fill_cnt; i < 64; i++)
                    blk_buf[i] = 8'h00;
                sha1_compress();
                fill_cnt = 0;
            end
            for (i = fill_cnt; i < 56; i++)
                blk_buf[i] = 8'h00;
            bit_len = {msg_len, 3'b000};
            for (i = 0; i < 8; i++)
                blk_buf[56+i] = bit_len[63-8*i -: 8];
            sha1_compress();
            if (keep) begin
                for (i = 0; i < 5; i++) begin
                    db.word = chain_h[i];
                    db.idx  = 3'(i);
                    db.last = (i == 4);
                    digest_expect_q.push_back(db);
                end
            end
            sha1_restart();
        end
    endtask

    task automatic add_row(input logic req, input logic [7:0] data_b, input bit typed,
                           input logic [159:0] digest);
        t_stim_row r;
        r.req    = req;
        r.data_b = data_b;
        r.typed  = typed;
        r.digest = digest;
        dir_rows.push_back(r);
    endtask

    task automatic send_beat(input logic req, input logic [7:0] data_b, input bit keep);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_s_axis_tvalid = 1'b0;
                i_s_axis_tdata  = 8'($urandom);
                i_s_axis_tuser  = 1'($urandom);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = data_b;
        i_s_axis_tuser  = req;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        absorb_beat(req, data_b, keep);
        items_sent++;
    endtask

    always @(posedge i_clk) begin
        t_digest_beat want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            rx_beats++;
            if (digest_expect_q.size() == 0) begin
                report_mismatch("digest beat with nothing pending", o_m_axis_tdata, 32'h0);
            end else begin
                want = digest_expect_q.pop_front();
                if (o_m_axis_tdata !== want.word)
                    report_mismatch("digest word", o_m_axis_tdata, want.word);
                if (o_m_axis_tuser !== want.idx)
                    report_mismatch("word index", 32'(o_m_axis_tuser), 32'(want.idx));
                if (o_m_axis_tlast !== want.last)
                    report_mismatch("last flag", 32'(o_m_axis_tlast), 32'(want.last));
            end
        end
    end

    // The receiver stalls on its own pattern and once holds off long enough to back up the input.
    initial begin
        int seg, mode, k;
        bit held;
        held = 1'b0;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && rx_beats >= 20) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_m_axis_tready = 1'b0;
                end
            end
            seg  = $urandom_range(10, 150);
            mode = $urandom_range(0, 2);
            for (k = 0; k < seg; k++) begin
                @(negedge i_clk);
                case (mode)
                    0: begin
                        i_m_axis_tready = 1'b1;
                    end
                    1: begin
                        i_m_axis_tready = 1'($urandom_range(0, 1));
                    end
                    default: begin
                        i_m_axis_tready = ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    initial begin
        int i, j, len, kind, fill_kind, waited;
        logic [7:0] data_b;
        t_digest_beat db;
        error_count     = 0;
        items_sent      = 0;
        rx_beats        = 0;
        burst_left      = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tuser  = sha1s_pkg::REQ_DATA;
        sha1_restart();
        for (i = 0; i < 64; i++)
            blk_buf[i] = 8'h00;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_row(sha1s_pkg::REQ_FINALIZE, 8'h00, 1'b1, DIGEST_EMPTY);
        add_row(sha1s_pkg::REQ_FINALIZE, 8'hFF, 1'b1, DIGEST_EMPTY);
        add_row(sha1s_pkg::REQ_DATA,     8'h61, 1'b0, '0);
        add_row(sha1s_pkg::REQ_DATA,     8'h62, 1'b0, '0);
        add_row(sha1s_pkg::REQ_DATA,     8'h63, 1'b0, '0);
        add_row(sha1s_pkg::REQ_FINALIZE, 8'hA5, 1'b1, DIGEST_ABC);
        add_row(sha1s_pkg::REQ_DATA,     8'h00, 1'b0, '0);
        add_row(sha1s_pkg::REQ_DATA,     8'hFF, 1'b0, '0);
        add_row(sha1s_pkg::REQ_FINALIZE, 8'hFF, 1'b0, '0);
        add_row(sha1s_pkg::REQ_DATA,     8'h80, 1'b0, '0);
        add_row(sha1s_pkg::REQ_DATA,     8'h7F, 1'b0, '0);
        add_row(sha1s_pkg::REQ_DATA,     8'h01, 1'b0, '0);
        add_row(sha1s_pkg::REQ_DATA,     8'hFE, 1'b0, '0);
        add_row(sha1s_pkg::REQ_FINALIZE, 8'h00, 1'b0, '0);
        add_row(sha1s_pkg::REQ_DATA,     8'hFF, 1'b0, '0);
        add_row(sha1s_pkg::REQ_FINALIZE, 8'h55, 1'b0, '0);

        foreach (dir_rows[r]) begin
            send_beat(dir_rows[r].req, dir_rows[r].data_b, !dir_rows[r].typed);
            if (dir_rows[r].typed) begin
                for (j = 0; j < 5; j++) begin
                    db.word = dir_rows[r].digest[159-32*j -: 32];
                    db.idx  = 3'(j);
                    db.last = (j == 4);
                    digest_expect_q.push_back(db);
                end
            end
        end

        // Whole messages with random content; lengths lean on the padding boundaries.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
                len = 0;
            else if (kind < 28)
                len = boundary_lens[$urandom_range(0, 8)];
            else
                len = $urandom_range(1, 40);
            fill_kind = $urandom_range(0, 9);
            for (j = 0; j < len; j++) begin
                if (fill_kind == 0)
                    data_b = 8'h00;
                else if (fill_kind == 1)
                    data_b = 8'hFF;
                else
                    data_b = 8'($urandom);
                send_beat(sha1s_pkg::REQ_DATA, data_b, 1'b1);
            end
            send_beat(sha1s_pkg::REQ_FINALIZE, 8'($urandom), 1'b1);
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        waited = 0;
        while (digest_expect_q.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (300) @(posedge i_clk);
        if (digest_expect_q.size() != 0)
            report_mismatch("digest words never delivered", digest_expect_q.size(), 32'h0);

        if (error_count == 0) begin
            $display("sha1_stream_hasher_top regression: pass");
        end else begin
            $display("sha1_stream_hasher_top regression: fail");
        end
        $finish;
    end

endmodule
